@@ hdl/smid_pkg.sv @@
// Shared types and constants for the small matrix inverse and determinant block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package smid_pkg;

  localparam int ELEM_W = 32;
  localparam int COF_W  = 64;
  localparam int DET_W  = 128;
  localparam int DMAG_W = 100;
  localparam int QB     = 32;
  localparam int DIV_W  = DMAG_W + QB;
  localparam int NELEM  = 9;
  localparam int NROW   = 3;

  localparam logic [1:0] DIM_NONE  = 2'd0;
  localparam logic [1:0] DIM_ONE   = 2'd1;
  localparam logic [1:0] DIM_TWO   = 2'd2;
  localparam logic [1:0] DIM_THREE = 2'd3;

  // Each 3x3 cofactor is a[PA_L]*a[PA_R] - a[PB_L]*a[PB_R].
  localparam int PA_L [NELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PA_R [NELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int PB_L [NELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int PB_R [NELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic [1:0]               dim;
    logic signed [ELEM_W-1:0] a00;
    logic signed [ELEM_W-1:0] a01;
    logic signed [ELEM_W-1:0] a02;
    logic signed [ELEM_W-1:0] a10;
    logic signed [ELEM_W-1:0] a11;
    logic signed [ELEM_W-1:0] a12;
    logic signed [ELEM_W-1:0] a20;
    logic signed [ELEM_W-1:0] a21;
    logic signed [ELEM_W-1:0] a22;
  } smid_in_beat_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] det;
    logic signed [ELEM_W-1:0] b00;
    logic signed [ELEM_W-1:0] b01;
    logic signed [ELEM_W-1:0] b02;
    logic signed [ELEM_W-1:0] b10;
    logic signed [ELEM_W-1:0] b11;
    logic signed [ELEM_W-1:0] b12;
    logic signed [ELEM_W-1:0] b20;
    logic signed [ELEM_W-1:0] b21;
    logic signed [ELEM_W-1:0] b22;
    logic                     singular;
    logic                     saturated;
  } smid_out_beat_t;

  typedef struct packed {
    logic             neg;
    logic [COF_W-1:0] mag;
  } smid_cof_t;

  typedef struct packed {
    logic [1:0]        dim;
    logic              dneg;
    logic              dzero;
    logic [DMAG_W-1:0] dmag;
  } smid_det_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] det;
    logic                     singular;
    logic                     clip;
  } smid_dres_t;

endpackage

@@ hdl/smid_if.sv @@
// Valid/ready channel interfaces for the input and result beats.
// Depends on smid_pkg for the beat types.
`timescale 1ns / 1ps

interface smid_in_if import smid_pkg::*; ();
  logic          valid;
  logic          ready;
  smid_in_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

interface smid_out_if import smid_pkg::*; ();
  logic           valid;
  logic           ready;
  smid_out_beat_t beat;
  modport source (output valid, output beat, input ready);
  modport sink (input valid, input beat, output ready);
endinterface

@@ hdl/small_matrix_inverse_det_top.sv @@
// Top level of the small matrix inverse and determinant block.
// Depends on smid_pkg, smid_if, smid_cofactor and smid_lane.
//
// Usage: each input beat carries a dimension (1, 2 or 3) and a row-major
// 3x3 matrix in signed fixed point. Each accepted beat yields exactly one
// result beat with the determinant, the inverse, and singular and
// saturated flags. Elements outside the used block read as zero.
// The block accepts one beat per cycle and returns one per cycle while the receiver does not stall.
// The pipeline has five cofactor and determinant stages, a
// 34-stage divider in each of the nine element lanes, one output register.
// The divider lanes resolve one quotient bit per stage, which sets the
// depth of the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and in_bus.ready drops; once the result is taken, the pipeline
// moves again in the same cycle.
// Reset clears the valid pipeline and the output valid; data registers
// are not reset.
`timescale 1ns / 1ps

module small_matrix_inverse_det_top import smid_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  smid_in_if.sink     in_bus,
  smid_out_if.source  out_bus
);

  localparam int COF_LAT  = 5;
  localparam int LANE_LAT = QB + 2;
  localparam int VLEN     = COF_LAT + LANE_LAT;

  logic                     en;
  logic [VLEN-1:0]          v_r;
  logic                     out_valid_r;
  smid_out_beat_t           out_beat_r;
  smid_out_beat_t           beat_nxt;

  smid_cof_t                cof [NELEM];
  smid_det_t                det;
  smid_cof_t                lane_in [NELEM];
  logic signed [ELEM_W-1:0] lane_q [NELEM];
  logic [NELEM-1:0]         lane_clip;

  logic [DMAG_W-1:0]        dq;
  logic [QB:0]              dlim;
  logic                     dclip;
  logic [QB-1:0]            dm;
  logic [QB-1:0]            dres;
  smid_dres_t               dres_nxt;
  smid_dres_t               dl_r [LANE_LAT];

  assign en           = !out_valid_r || out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[VLEN-2:0], in_bus.valid};
      out_valid_r <= v_r[VLEN-1];
    end
  end

  smid_cofactor u_cof (
    .clk    (clk),
    .en     (en),
    .beat_i (in_bus.beat),
    .cof_o  (cof),
    .det_o  (det)
  );

  for (genvar i = 0; i < NELEM; i++) begin : g_lane
    assign lane_in[i].neg = cof[i].neg ^ det.dneg;
    assign lane_in[i].mag = cof[i].mag;

    smid_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .en     (en),
      .lane_i (lane_in[i]),
      .dmag_i (det.dmag),
      .q_o    (lane_q[i]),
      .clip_o (lane_clip[i])
    );
  end

  always_comb begin
    unique case (det.dim)
      DIM_THREE: dq = det.dmag >> (2 * FRAC_BITS);
      DIM_TWO:   dq = det.dmag >> FRAC_BITS;
      DIM_ONE:   dq = det.dmag;
      DIM_NONE:  dq = '0;
    endcase
  end

  assign dlim  = det.dneg ? {2'b01, {(QB-1){1'b0}}} : {2'b00, {(QB-1){1'b1}}};
  assign dclip = (dq > DMAG_W'(dlim));
  assign dm    = dclip ? dlim[QB-1:0] : dq[QB-1:0];
  assign dres  = det.dneg ? (~dm + QB'(1)) : dm;

  always_comb begin
    if (det.dzero) begin
      dres_nxt.det      = '0;
      dres_nxt.singular = 1'b1;
      dres_nxt.clip     = 1'b0;
    end else begin
      dres_nxt.det      = $signed(dres);
      dres_nxt.singular = 1'b0;
      dres_nxt.clip     = dclip;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= dres_nxt;
      for (int k = 1; k < LANE_LAT; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  always_comb begin
    beat_nxt.det       = dl_r[LANE_LAT-1].det;
    beat_nxt.singular  = dl_r[LANE_LAT-1].singular;
    beat_nxt.saturated = !dl_r[LANE_LAT-1].singular
                         && (dl_r[LANE_LAT-1].clip || (|lane_clip));
    if (dl_r[LANE_LAT-1].singular) begin
      beat_nxt.b00 = '0;
      beat_nxt.b01 = '0;
      beat_nxt.b02 = '0;
      beat_nxt.b10 = '0;
      beat_nxt.b11 = '0;
      beat_nxt.b12 = '0;
      beat_nxt.b20 = '0;
      beat_nxt.b21 = '0;
      beat_nxt.b22 = '0;
    end else begin
      beat_nxt.b00 = lane_q[0];
      beat_nxt.b01 = lane_q[1];
      beat_nxt.b02 = lane_q[2];
      beat_nxt.b10 = lane_q[3];
      beat_nxt.b11 = lane_q[4];
      beat_nxt.b12 = lane_q[5];
      beat_nxt.b20 = lane_q[6];
      beat_nxt.b21 = lane_q[7];
      beat_nxt.b22 = lane_q[8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_beat_r <= beat_nxt;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.beat  = out_beat_r;

endmodule

@@ hdl/smid_cofactor.sv @@
// Five-stage pipeline that forms the cofactors and the exact determinant.
// Depends on smid_pkg.
`timescale 1ns / 1ps

module smid_cofactor import smid_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  smid_in_beat_t beat_i,
  output smid_cof_t     cof_o [NELEM],
  output smid_det_t     det_o
);

  logic signed [ELEM_W-1:0] a [NELEM];
  logic signed [ELEM_W-1:0] a_r [NELEM];
  logic [1:0]               dim_a_r;
  logic signed [COF_W-1:0]  pa_r [NELEM];
  logic signed [COF_W-1:0]  pb_r [NELEM];

  logic signed [COF_W-1:0]  c_nxt [NELEM];
  logic signed [COF_W-1:0]  c_r [NELEM];
  logic signed [ELEM_W-1:0] ab_r [NROW];
  logic [1:0]               dim_b_r;

  logic signed [COF_W-1:0]  cc_r [NELEM];
  logic signed [COF_W-1:0]  pph_r [NROW];
  logic signed [COF_W-1:0]  ppl_r [NROW];
  logic [1:0]               dim_c_r;

  logic signed [DET_W-1:0]  d_nxt;
  logic signed [DET_W-1:0]  d_r;
  logic signed [COF_W-1:0]  cd_r [NELEM];
  logic [1:0]               dim_d_r;

  logic [DET_W-1:0]         dabs;
  smid_cof_t                cof_r [NELEM];
  smid_det_t                det_r;

  assign a[0] = beat_i.a00;
  assign a[1] = beat_i.a01;
  assign a[2] = beat_i.a02;
  assign a[3] = beat_i.a10;
  assign a[4] = beat_i.a11;
  assign a[5] = beat_i.a12;
  assign a[6] = beat_i.a20;
  assign a[7] = beat_i.a21;
  assign a[8] = beat_i.a22;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NELEM; i++) begin
        a_r[i]  <= a[i];
        pa_r[i] <= $signed(a[PA_L[i]]) * $signed(a[PA_R[i]]);
        pb_r[i] <= $signed(a[PB_L[i]]) * $signed(a[PB_R[i]]);
      end
      dim_a_r <= beat_i.dim;
    end
  end

  always_comb begin
    for (int i = 0; i < NELEM; i++) begin
      c_nxt[i] = '0;
    end
    unique case (dim_a_r)
      DIM_THREE: begin
        for (int i = 0; i < NELEM; i++) begin
          c_nxt[i] = pa_r[i] - pb_r[i];
        end
      end
      DIM_TWO: begin
        c_nxt[0] = COF_W'(a_r[4]);
        c_nxt[1] = -COF_W'(a_r[1]);
        c_nxt[3] = -COF_W'(a_r[3]);
        c_nxt[4] = COF_W'(a_r[0]);
      end
      DIM_ONE: begin
        c_nxt[0] = COF_W'(1);
      end
      DIM_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NELEM; i++) begin
        c_r[i] <= c_nxt[i];
      end
      for (int j = 0; j < NROW; j++) begin
        ab_r[j] <= a_r[j];
      end
      dim_b_r <= dim_a_r;
    end
  end

  // The determinant row product a * c is split into two 32-bit halves of c.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NELEM; i++) begin
        cc_r[i] <= c_r[i];
      end
      for (int j = 0; j < NROW; j++) begin
        pph_r[j] <= $signed(ab_r[j]) * $signed(c_r[NROW*j][COF_W-1:ELEM_W]);
        ppl_r[j] <= $signed(ab_r[j]) * $signed({1'b0, c_r[NROW*j][ELEM_W-1:0]});
      end
      dim_c_r <= dim_b_r;
    end
  end

  always_comb begin
    d_nxt = '0;
    for (int j = 0; j < NROW; j++) begin
      d_nxt = d_nxt + $signed({{ELEM_W{pph_r[j][COF_W-1]}}, pph_r[j], {ELEM_W{1'b0}}})
                    + DET_W'(ppl_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      for (int i = 0; i < NELEM; i++) begin
        cd_r[i] <= cc_r[i];
      end
      dim_d_r <= dim_c_r;
    end
  end

  assign dabs = d_r[DET_W-1] ? DET_W'(-d_r) : DET_W'(d_r);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NELEM; i++) begin
        cof_r[i].neg <= cd_r[i][COF_W-1];
        cof_r[i].mag <= cd_r[i][COF_W-1] ? COF_W'(-cd_r[i]) : COF_W'(cd_r[i]);
      end
      det_r.dim   <= dim_d_r;
      det_r.dneg  <= d_r[DET_W-1];
      det_r.dzero <= (d_r == '0);
      det_r.dmag  <= dabs[DMAG_W-1:0];
    end
  end

  assign cof_o = cof_r;
  assign det_o = det_r;

endmodule

@@ hdl/smid_lane.sv @@
// One inverse-element lane: a pipelined restoring divider of the shifted
// cofactor by the determinant, with saturation. Depends on smid_pkg.
`timescale 1ns / 1ps

module smid_lane import smid_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  smid_cof_t                lane_i,
  input  logic [DMAG_W-1:0]        dmag_i,
  output logic signed [ELEM_W-1:0] q_o,
  output logic                     clip_o
);

  logic [DIV_W-1:0]  num;
  logic [DIV_W-1:0]  dlim;
  logic [DIV_W-1:0]  rem_r [QB];
  logic [DMAG_W-1:0] dv_r [QB];
  logic [QB-1:0]     q_r [QB+1];
  logic              neg_r [QB+1];
  logic              act_r [QB+1];
  logic              ovf_r [QB+1];
  logic [QB:0]       lim;
  logic              clip;
  logic [QB-1:0]     m;
  logic [QB-1:0]     res;
  logic signed [ELEM_W-1:0] q_out_r;
  logic              clip_r;

  assign num  = DIV_W'(lane_i.mag) << (2 * FRAC_BITS);
  assign dlim = {dmag_i, {QB{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      dv_r[0]  <= dmag_i;
      q_r[0]   <= '0;
      neg_r[0] <= lane_i.neg;
      act_r[0] <= |lane_i.mag;
      ovf_r[0] <= (num >= dlim);
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int SH = QB - 1 - s;
    logic [DIV_W-1:0] trial;
    logic             ge;

    assign trial = DIV_W'(dv_r[s]) << SH;
    assign ge    = (rem_r[s] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s+1]   <= q_r[s] | (QB'(ge) << SH);
        neg_r[s+1] <= neg_r[s];
        act_r[s+1] <= act_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end

    if (s < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= ge ? (rem_r[s] - trial) : rem_r[s];
          dv_r[s+1]  <= dv_r[s];
        end
      end
    end
  end

  assign lim  = neg_r[QB] ? {2'b01, {(QB-1){1'b0}}} : {2'b00, {(QB-1){1'b1}}};
  assign clip = act_r[QB] & (ovf_r[QB] | ({1'b0, q_r[QB]} > lim));
  assign m    = clip ? lim[QB-1:0] : q_r[QB];
  assign res  = neg_r[QB] ? (~m + QB'(1)) : m;

  always_ff @(posedge clk) begin
    if (en) begin
      q_out_r <= act_r[QB] ? $signed(res) : '0;
      clip_r  <= clip;
    end
  end

  assign q_o    = q_out_r;
  assign clip_o = clip_r;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for small_matrix_inverse_det_top: random and directed
// matrices, with a bit-exact predictor of determinant and inverse.
// Depends on smid_pkg, smid_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import smid_pkg::*;

  localparam int FB = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   n_fail = 0;
  int   n_checked = 0;
  int   n_singular = 0;
  int   n_clipped = 0;
  int   src_idle = 26;
  int   snk_idle = 47;
  bit   in_fire = 1'b0;

  smid_in_beat_t  pending_mats[$];
  smid_out_beat_t expected_results[$];

  smid_in_if  in_bus ();
  smid_out_if out_bus ();

  small_matrix_inverse_det_top #(.FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] clip32(input logic neg, input logic [255:0] mag,
                                         inout logic clip);
    logic [255:0] lim;
    lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
    if (mag > lim) begin
      mag = lim;
      clip = 1'b1;
    end
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  function automatic smid_out_beat_t invert_matrix(input smid_in_beat_t m);
    smid_out_beat_t r;
    logic signed [255:0] a [9];
    logic signed [255:0] c [9];
    logic signed [255:0] d;
    logic [255:0] dmag;
    logic [255:0] q;
    logic [31:0]  b [9];
    logic dneg;
    logic clip;
    int n;
    r = '0;
    clip = 1'b0;
    a = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
    foreach (c[i]) c[i] = 0;
    foreach (b[i]) b[i] = '0;
    n = m.dim;
    case (m.dim)
      DIM_THREE: begin
        c[0] = a[4]*a[8] - a[5]*a[7];
        c[1] = a[2]*a[7] - a[1]*a[8];
        c[2] = a[1]*a[5] - a[2]*a[4];
        c[3] = a[5]*a[6] - a[3]*a[8];
        c[4] = a[0]*a[8] - a[2]*a[6];
        c[5] = a[2]*a[3] - a[0]*a[5];
        c[6] = a[3]*a[7] - a[4]*a[6];
        c[7] = a[1]*a[6] - a[0]*a[7];
        c[8] = a[0]*a[4] - a[1]*a[3];
        d = a[0]*c[0] + a[1]*c[3] + a[2]*c[6];
      end
      DIM_TWO: begin
        c[0] = a[4]; c[1] = -a[1]; c[3] = -a[3]; c[4] = a[0];
        d = a[0]*a[4] - a[1]*a[3];
      end
      DIM_ONE: begin
        c[0] = 1;
        d = a[0];
      end
      default: d = 0;
    endcase
    if (d == 0) begin
      r.singular = 1'b1;
      return r;
    end
    dneg = d < 0;
    dmag = dneg ? -d : d;
    r.det = clip32(dneg, dmag >> ((n - 1) * FB), clip);
    for (int i = 0; i < 9; i++) begin
      if (i / 3 < n && i % 3 < n && c[i] != 0) begin
        q = ((c[i] < 0 ? -c[i] : c[i]) << (2 * FB)) / dmag;
        if (q != 0) b[i] = clip32((c[i] < 0) != dneg, q, clip);
      end
    end
    {r.b00, r.b01, r.b02, r.b10, r.b11, r.b12, r.b20, r.b21, r.b22} =
      {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], b[8]};
    r.saturated = clip;
    return r;
  endfunction

  function automatic logic [31:0] random_elem();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      6: return $signed($urandom_range(0, 255)) - 32'sd128;
      default: return $urandom;
    endcase
  endfunction

  function automatic smid_in_beat_t random_matrix();
    smid_in_beat_t m;
    m.dim = $urandom_range(0, 9) == 0 ? DIM_NONE : 2'($urandom_range(1, 3));
    m.a00 = random_elem(); m.a01 = random_elem(); m.a02 = random_elem();
    m.a10 = random_elem(); m.a11 = random_elem(); m.a12 = random_elem();
    m.a20 = random_elem(); m.a21 = random_elem(); m.a22 = random_elem();
    if ($urandom_range(0, 7) == 0) begin
      m.a10 = m.a00; m.a11 = m.a01; m.a12 = m.a02;
    end
    return m;
  endfunction

  function automatic smid_in_beat_t diag_matrix(input logic [1:0] dim, input logic [31:0] v);
    smid_in_beat_t m;
    m = '0;
    m.dim = dim;
    m.a00 = v; m.a11 = v; m.a22 = v;
    return m;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.beat <= '0;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= $urandom_range(0, 99) >= snk_idle;
      if (!in_bus.valid || in_fire) begin
        if (pending_mats.size() > 0 && $urandom_range(0, 99) >= src_idle) begin
          in_bus.valid <= 1'b1;
          in_bus.beat <= pending_mats.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    smid_out_beat_t want;
    in_fire = rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        expected_results.push_back(invert_matrix(in_bus.beat));
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_bus.beat);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          n_singular += want.singular;
          n_clipped += want.saturated;
          if (out_bus.beat !== want) begin
            $display("%0t: mismatch dim-matrix result: expected %h actual %h", $time,
                     want, out_bus.beat);
            n_fail++;
          end
        end
      end
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.beat = '0;
    out_bus.ready = 1'b0;
    for (int d = 0; d < 4; d++) begin
      pending_mats.push_back(diag_matrix(2'(d), 32'h0001_0000));
      pending_mats.push_back(diag_matrix(2'(d), 32'h8000_0000));
      pending_mats.push_back(diag_matrix(2'(d), 32'h7FFF_FFFF));
      pending_mats.push_back(diag_matrix(2'(d), 32'h0000_0001));
      pending_mats.push_back(diag_matrix(2'(d), 32'h0));
    end
    pending_mats.push_back(diag_matrix(DIM_ONE, 32'hFFFF_FFFF));
    pending_mats.push_back(diag_matrix(DIM_TWO, 32'h0000_0100));
    pending_mats.push_back(smid_in_beat_t'{DIM_THREE, 1, 2, 3, 4, 5, 6, 7, 8, 9});
    pending_mats.push_back(smid_in_beat_t'{DIM_TWO, 32'h0002_0000, 32'h0001_0000,
                                           32'hFFFF_0000, 32'h0003_0000, 32'hFFFF_FFFF,
                                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                           32'hFFFF_FFFF});
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < 2000; k++) begin
      if (k == 700) begin
        src_idle = 47;
        snk_idle = 26;
      end else if (k == 1400) begin
        src_idle = 0;
        snk_idle = 0;
      end
      pending_mats.push_back(random_matrix());
      while (pending_mats.size() > 8) @(posedge clk);
    end
    while (pending_mats.size() > 0 || in_bus.valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Checked %0d results, %0d singular and %0d saturated.", n_checked,
             n_singular, n_clipped);
    if (n_fail == 0)
      $display("small_matrix_inverse_det_top verification clean");
    else
      $display("small_matrix_inverse_det_top verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("small_matrix_inverse_det_top verification failed");
    $finish;
  end

endmodule
